>>> hdl/countdown_timer_bank_core_macros.svh
// Assertion macros shared by the checker. Each expects clk_i and rst_ni in scope.
`ifndef COUNTDOWN_TIMER_BANK_CORE_MACROS_SVH
`define COUNTDOWN_TIMER_BANK_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CTB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("countdown timer bank: assertion failed");

// Next-cycle implication, disabled during reset.
`define CTB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("countdown timer bank: assertion failed");

`endif

>>> hdl/ctb_pkg.sv
package ctb_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_STOP   = 3'd2,
    OP_RESUME = 3'd3,
    OP_CHECK  = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_STOPPED = 2'd0,
    ST_RUNNING = 2'd1,
    ST_READY   = 2'd2
  } run_state_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_APPLY,
    S_REPORT
  } fsm_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  timer_index;
    logic [15:0] start_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  timer_state;
    logic [15:0] timer_count;
    logic        was_ready;
  } result_t;

endpackage

>>> hdl/countdown_timer_bank_core.sv
// busy_o is high from acceptance until the result strobe, so the block takes no new item
// before the last is through; a tick walks over the timers, one timer per cycle through a
// single decrement unit, and a command updates only its addressed timer.
// The receiver cannot stall: done_o is valid for exactly one cycle; result_o holds until the next result.
// Reset (rst_ni low, asynchronous) stops every timer, clears every count and idles the block.
module countdown_timer_bank_core
  import ctb_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  cmd_t    cmd_i,
  output logic    busy_o,
  output logic    done_o,
  output result_t result_o
);

  fsm_e            fsm_q, fsm_d;
  cmd_t            cmd_q;
  logic            idx_ok_q;
  logic [IdxW-1:0] walk_q, walk_d;
  logic            flag_q, flag_d;

  run_state_e      run_q [NUM_TIMERS];
  logic [15:0]     cnt_q [NUM_TIMERS];

  logic            accept;
  logic            wr_en;
  logic [IdxW-1:0] addr;
  logic [IdxW-1:0] cmd_addr;
  run_state_e      rd_state, upd_state;
  logic [15:0]     rd_count, upd_count;
  logic            upd_flag;
  logic            walk_last;

  result_t         result_q, result_d;
  logic            done_q, done_d;

  assign accept    = start_i && !busy_o;
  assign cmd_addr  = IdxW'(cmd_q.timer_index);
  assign walk_last = (walk_q == IdxW'(NUM_TIMERS - 1));

  // Next state.
  always_comb begin
    fsm_d = fsm_q;
    unique case (fsm_q)
      S_IDLE: begin
        if (accept) begin
          fsm_d = (cmd_i.opcode == OP_TICK) ? S_WALK : S_APPLY;
        end
      end
      S_WALK: begin
        if (walk_last) begin
          fsm_d = S_REPORT;
        end
      end
      S_APPLY:  fsm_d = S_REPORT;
      S_REPORT: fsm_d = S_IDLE;
      default:  fsm_d = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy_o = 1'b1;
    wr_en  = 1'b0;
    addr   = cmd_addr;
    walk_d = walk_q;
    flag_d = flag_q;
    done_d = 1'b0;
    unique case (fsm_q)
      S_IDLE: begin
        busy_o = 1'b0;
        walk_d = '0;
        flag_d = 1'b0;
      end
      S_WALK: begin
        addr   = walk_q;
        wr_en  = 1'b1;
        walk_d = walk_q + IdxW'(1);
      end
      S_APPLY: begin
        wr_en  = idx_ok_q;
        flag_d = upd_flag && idx_ok_q;
      end
      S_REPORT: done_d = 1'b1;
      default: ;
    endcase
  end

  assign rd_state = run_q[addr];
  assign rd_count = cnt_q[addr];

  // Shared update unit: one timer per cycle, for the walk or for a single command.
  always_comb begin
    upd_state = rd_state;
    upd_count = rd_count;
    upd_flag  = 1'b0;
    if (fsm_q == S_WALK) begin
      if (rd_state == ST_RUNNING) begin
        if (rd_count <= 16'd1) begin
          upd_count = '0;
          upd_state = ST_READY;
        end else begin
          upd_count = rd_count - 16'd1;
        end
      end
    end else begin
      case (cmd_q.opcode)
        OP_START: begin
          upd_count = cmd_q.start_value;
          upd_state = ST_RUNNING;
        end
        OP_STOP:   upd_state = ST_STOPPED;
        OP_RESUME: upd_state = ST_RUNNING;
        OP_CHECK: begin
          if (rd_state == ST_READY) begin
            upd_state = ST_STOPPED;
            upd_flag  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result_d = result_q;
    if (fsm_q == S_REPORT) begin
      result_d.timer_state = idx_ok_q ? rd_state : ST_STOPPED;
      result_d.timer_count = idx_ok_q ? rd_count : 16'd0;
      result_d.was_ready   = flag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q  <= S_IDLE;
      walk_q <= '0;
      flag_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      fsm_q  <= fsm_d;
      walk_q <= walk_d;
      flag_q <= flag_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_TIMERS; k++) begin
        run_q[k] <= ST_STOPPED;
        cnt_q[k] <= '0;
      end
    end else if (wr_en) begin
      run_q[addr] <= upd_state;
      cnt_q[addr] <= upd_count;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_i;
      idx_ok_q <= (32'(cmd_i.timer_index) < NUM_TIMERS);
    end
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

>>> hdl/ctb_checker.sv
`include "countdown_timer_bank_core_macros.svh"

module ctb_checker
  import ctb_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start_i,
  input logic    busy_o,
  input logic    done_o,
  input result_t result_o
);

  // A result is only shown once the block has gone idle again.
  `CTB_ASSERT_IMP(a_done_idle, done_o, !busy_o)
  // An accepted item keeps the block busy in the following cycle.
  `CTB_ASSERT_NXT(a_accept_busy, start_i && !busy_o, busy_o)
  // Each result strobe lasts a single cycle.
  `CTB_ASSERT_NXT(a_done_single, done_o, !done_o)
  // A timer only becomes ready with a zero count, so a cleared ready flag leaves it
  // stopped at zero.
  `CTB_ASSERT_IMP(a_ready_clear, done_o && result_o.was_ready,
                  result_o.timer_state == ST_STOPPED && result_o.timer_count == 16'd0)

endmodule

bind countdown_timer_bank_core ctb_checker u_ctb_checker (.*);
